[rtl/jcs_pkg.sv]
// ----------------------------------------------------------------------------
// Joystick conditioner package
// Shared widths, op codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package jcs_pkg;

	// Field widths.
	localparam int SampleW = 8;
	localparam int PosW    = 8;
	localparam int OpW     = 2;

	// Op codes carried by each request.
	localparam logic [OpW-1:0] OpCenter  = 2'd0;
	localparam logic [OpW-1:0] OpCalib   = 2'd1;
	localparam logic [OpW-1:0] OpMeasure = 2'd2;

	// Scaling constants and reset values.
	localparam int PosScale = 100;
	localparam logic [SampleW-1:0] SampleMax = 8'hFF;
	localparam logic [SampleW-1:0] SampleMin = 8'h00;

	// |s - center| * 100 is at most 25500, which fits 15 bits.
	localparam int NumW     = 15;
	localparam int DivSteps = NumW;
	localparam int CntW     = $clog2(DivSteps);

	// Number of axes processed side by side.
	localparam int Lanes = 2;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic step;
		logic write_out;
	} jcs_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic in_measure;
	} jcs_status_t;

endpackage

[rtl/jcs_in_if.sv]
// ----------------------------------------------------------------------------
// Joystick conditioner input channel
// Valid/ready channel carrying one op code and an x,y sample pair.
// ----------------------------------------------------------------------------
interface jcs_in_if import jcs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OpW-1:0]     op;
	logic [SampleW-1:0] x_sample;
	logic [SampleW-1:0] y_sample;

	modport source (output valid, output op, output x_sample, output y_sample, input ready);
	modport sink   (input valid, input op, input x_sample, input y_sample, output ready);
endinterface

[rtl/jcs_out_if.sv]
// ----------------------------------------------------------------------------
// Joystick conditioner output channel
// Valid/ready channel carrying the scaled position and the span fault flag.
// ----------------------------------------------------------------------------
interface jcs_out_if import jcs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [PosW-1:0] x_pos;
	logic signed [PosW-1:0] y_pos;
	logic                   span_fault;

	modport source (output valid, output x_pos, output y_pos, output span_fault, input ready);
	modport sink   (input valid, input x_pos, input y_pos, input span_fault, output ready);
endinterface

[rtl/jcs_dp.sv]
// ----------------------------------------------------------------------------
// Joystick conditioner datapath
// Holds the calibration state, prepares both axes for division, runs two
// restoring dividers one quotient bit per step and keeps the output register.
// ----------------------------------------------------------------------------
module jcs_dp import jcs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  jcs_cmd_t               cmd,
	output jcs_status_t            st,
	input  logic [OpW-1:0]         op,
	input  logic [SampleW-1:0]     x_sample,
	input  logic [SampleW-1:0]     y_sample,
	output logic signed [PosW-1:0] x_pos,
	output logic signed [PosW-1:0] y_pos,
	output logic                   span_fault
);

	// Calibration state.
	logic [SampleW-1:0] center_x_q, center_y_q;
	logic [SampleW-1:0] high_x_q, high_y_q;
	logic [SampleW-1:0] low_x_q, low_y_q;

	// Per-axis views of the sample and calibration.
	logic [SampleW-1:0] smp [Lanes];
	logic [SampleW-1:0] ctr [Lanes];
	logic [SampleW-1:0] hi  [Lanes];
	logic [SampleW-1:0] lo  [Lanes];

	// Preparation results.
	logic               above    [Lanes];
	logic [SampleW-1:0] diff_mag [Lanes];
	logic [NumW-1:0]    num_mag  [Lanes];
	logic [SampleW:0]   den      [Lanes];
	logic [SampleW:0]   den_abs  [Lanes];
	logic               den_zero [Lanes];
	logic               res_neg  [Lanes];

	// Divider state.
	logic [NumW-1:0]    dvd_q  [Lanes];
	logic [SampleW-1:0] rem_q  [Lanes];
	logic [SampleW-1:0] dmag_q [Lanes];
	logic               neg_q  [Lanes];
	logic               zero_q [Lanes];
	logic               meas_q;

	// Divider step and final result.
	logic [SampleW:0]   trial  [Lanes];
	logic               fits   [Lanes];
	logic [PosW-2:0]    sat    [Lanes];
	logic [PosW-1:0]    res    [Lanes];

	// Output register.
	logic [PosW-1:0] x_pos_q, y_pos_q;
	logic            fault_q;

	assign smp[0] = x_sample;
	assign smp[1] = y_sample;
	assign ctr[0] = center_x_q;
	assign ctr[1] = center_y_q;
	assign hi[0]  = high_x_q;
	assign hi[1]  = high_y_q;
	assign lo[0]  = low_x_q;
	assign lo[1]  = low_y_q;

	assign st.in_measure = (op == OpMeasure);

	// Calibration state updates on an accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= SampleMin;
			center_y_q <= SampleMin;
			high_x_q   <= SampleMin;
			high_y_q   <= SampleMin;
			low_x_q    <= SampleMax;
			low_y_q    <= SampleMax;
		end else if (cmd.load) begin
			case (op)
				OpCenter: begin
					center_x_q <= x_sample;
					center_y_q <= y_sample;
				end
				OpCalib: begin
					if (x_sample > high_x_q) high_x_q <= x_sample;
					if (y_sample > high_y_q) high_y_q <= y_sample;
					if (x_sample < low_x_q)  low_x_q  <= x_sample;
					if (y_sample < low_y_q)  low_y_q  <= y_sample;
				end
				default: begin
				end
			endcase
		end
	end

	// Split each axis into a numerator magnitude, a divisor magnitude and a sign.
	always_comb begin
		for (int i = 0; i < Lanes; i++) begin
			above[i]    = smp[i] > ctr[i];
			diff_mag[i] = above[i] ? (smp[i] - ctr[i]) : (ctr[i] - smp[i]);
			num_mag[i]  = NumW'({{(NumW-SampleW){1'b0}}, diff_mag[i]} * NumW'(PosScale));
			den[i]      = above[i] ? ({1'b0, hi[i]} - {1'b0, ctr[i]})
			                       : ({1'b0, ctr[i]} - {1'b0, lo[i]});
			den_abs[i]  = den[i][SampleW] ? (~den[i] + 1'b1) : den[i];
			den_zero[i] = (den[i] == '0);
			res_neg[i]  = (smp[i] < ctr[i]) ^ den[i][SampleW];
		end
	end

	// One restoring step per lane, then saturation and sign of the quotient.
	always_comb begin
		for (int i = 0; i < Lanes; i++) begin
			trial[i] = {rem_q[i], dvd_q[i][NumW-1]};
			fits[i]  = trial[i] >= {1'b0, dmag_q[i]};
			sat[i]   = (dvd_q[i] > NumW'(PosScale)) ? (PosW-1)'(PosScale)
			                                        : dvd_q[i][PosW-2:0];
			if (zero_q[i]) begin
				res[i] = '0;
			end else if (neg_q[i]) begin
				res[i] = ~{1'b0, sat[i]} + 1'b1;
			end else begin
				res[i] = {1'b0, sat[i]};
			end
		end
	end

	// Divider registers: loaded on accept, shifted one bit per step.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q <= st.in_measure;
			for (int i = 0; i < Lanes; i++) begin
				dvd_q[i]  <= num_mag[i];
				rem_q[i]  <= '0;
				dmag_q[i] <= den_abs[i][SampleW-1:0];
				neg_q[i]  <= res_neg[i];
				zero_q[i] <= den_zero[i];
			end
		end else if (cmd.step) begin
			for (int i = 0; i < Lanes; i++) begin
				rem_q[i] <= fits[i] ? SampleW'(trial[i] - {1'b0, dmag_q[i]})
				                    : trial[i][SampleW-1:0];
				dvd_q[i] <= {dvd_q[i][NumW-2:0], fits[i]};
			end
		end
	end

	// Output register; non-measure requests give an all-zero result.
	always_ff @(posedge clk) begin
		if (cmd.write_out) begin
			x_pos_q <= meas_q ? res[0] : '0;
			y_pos_q <= meas_q ? res[1] : '0;
			fault_q <= meas_q & (zero_q[0] | zero_q[1]);
		end
	end

	assign x_pos      = x_pos_q;
	assign y_pos      = y_pos_q;
	assign span_fault = fault_q;

endmodule

[rtl/jcs_ctrl.sv]
// ----------------------------------------------------------------------------
// Joystick conditioner controller
// Sequences accept, division steps and the write into the output register,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module jcs_ctrl import jcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  jcs_status_t st,
	output jcs_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0]      state_q, state_d;
	logic [CntW-1:0] cnt_q;
	logic            out_valid_q;
	logic            out_free;

	// The output register can take a result when empty or being emptied.
	assign out_free = !out_valid_q || out_ready;

	// Next state and commands.
	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.step      = 1'b0;
		cmd.write_out = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = st.in_measure ? S_DIV : S_OUT;
				end
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == CntW'(DivSteps - 1)) state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.write_out = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, step counter and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.write_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// Only one request is in flight at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request accepted while one is in flight");

	// A measure starts the divider from a cleared step count.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && st.in_measure |=> (state_q == S_DIV) && (cnt_q == '0))
		else $error("measure did not start the divider");

	// The divider runs exactly the full number of steps.
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) && (cnt_q == CntW'(DivSteps - 1)) |=> state_q == S_OUT)
		else $error("divider did not finish after the last step");

	// A written result is presented on the next cycle.
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_out |=> out_valid_q)
		else $error("result written but not presented");

endmodule

[rtl/joystick_calibrate_and_scale_top.sv]
// A measure request runs the 15-step restoring divider after acceptance and is
// then written to the output register; centre, calibration and unused op requests
// are written straight after acceptance. Each axis has its own divider. A request
// is taken only once the last is written; a write waits while an unread result is held.
// Reset: arst_n clears the centre to 0, maxima to 0, minima to 255, and empties
// the output register.
// ----------------------------------------------------------------------------
// Joystick calibrate and scale, top level
// Joins the controller and the datapath to the request channels.
// ----------------------------------------------------------------------------
module joystick_calibrate_and_scale_top import jcs_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	jcs_in_if.sink    in_ch,
	jcs_out_if.source out_ch
);

	jcs_cmd_t    cmd;
	jcs_status_t st;

	jcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.st        (st),
		.cmd       (cmd)
	);

	jcs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.op         (in_ch.op),
		.x_sample   (in_ch.x_sample),
		.y_sample   (in_ch.y_sample),
		.x_pos      (out_ch.x_pos),
		.y_pos      (out_ch.y_pos),
		.span_fault (out_ch.span_fault)
	);

endmodule
